// ----- rtl/hspf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hspf_pkg
// Shared types and constants for the HTTP session packet filter.
// ----------------------------------------------------------------------------
package hspf_pkg;

    localparam int SESSION_ENTRIES = 1024;
    localparam int IDX_W           = (SESSION_ENTRIES > 1) ? $clog2(SESSION_ENTRIES) : 1;
    localparam int COUNT_W         = $clog2(SESSION_ENTRIES + 1);
    localparam int KEY_W           = 96;
    localparam int IN_W            = 200;
    localparam int OUT_W           = 8;

    localparam logic [15:0] ETH_IPV4    = 16'h0800;
    localparam logic [7:0]  IP_TCP      = 8'd6;
    localparam logic [16:0] MIN_PAYLOAD = 17'd7;

    typedef enum logic [2:0] {
        V_NOT_IPV4 = 3'd0,
        V_NOT_TCP  = 3'd1,
        V_SHORT    = 3'd2,
        V_METHOD   = 3'd3,
        V_HIT      = 3'd4,
        V_NO_MATCH = 3'd5
    } t_verdict;

    typedef struct packed {
        logic load;     // capture the input item
        logic start;    // begin session scan
        logic insert;   // append key to the session set
    } t_cmd;

    typedef struct packed {
        logic     early;      // decided without the session set
        t_verdict early_verdict;
        logic     method;     // payload starts with an HTTP method
        logic     done;       // scan finished this cycle
        logic     hit;        // key found (valid with done)
        logic     full;       // session set full
    } t_status;

endpackage

// ----- rtl/http_session_packet_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_session_packet_filter
// Keep/drop decision per packet header summary with an HTTP session set.
// ----------------------------------------------------------------------------
// channel   dir  bits  content
// s_axis    in   200   one packet header summary
// m_axis    out  8     keep, verdict, insert_failed
//
// A packet decided from its headers skips the session scan; otherwise the
// stored keys are read in slot order (one key read per cycle) until a hit
// or the last stored key; an empty set ends the scan with no key read.
// Reset clears the session count and control; key memory needs no clearing.
// A finished result sits in the output register; the next item is taken
// while it waits, and its result is held until the register is free.
// ----------------------------------------------------------------------------
module http_session_packet_filter import hspf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // ether_type[15:0], ip_protocol[23:16], ip_header_words[27:24],
    // ip_total_length[43:28], tcp_offset_words[47:44], source_ip[79:48],
    // dest_ip[111:80], source_port[127:112], dest_port[143:128],
    // payload_head[199:144]
    input  logic [IN_W-1:0]  i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // keep[0], verdict[3:1], insert_failed[4], zero[7:5]
    output logic [OUT_W-1:0] o_m_axis_tdata
);
    t_cmd     cmd;
    t_status  status;
    t_verdict verdict;
    logic     fail, res_load, out_free;
    logic     r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    assign out_free = !r_out_valid || i_m_axis_tready;

    hspf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_out_free (out_free),
        .i_status   (status),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd),
        .o_res_load (res_load),
        .o_verdict  (verdict),
        .o_fail     (fail)
    );

    hspf_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_s_axis_tdata),
        .i_cmd    (cmd),
        .o_status (status)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out_data <= {3'b000, fail, verdict,
                           (verdict == V_METHOD) || (verdict == V_HIT)};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    a_fail_only_method: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[4] |-> r_out_data[3:1] == V_METHOD)
        else $error("insert failure without method match");

    a_keep_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_data[0] ==
            ((r_out_data[3:1] == V_METHOD) || (r_out_data[3:1] == V_HIT)))
        else $error("keep disagrees with verdict");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |-> !r_out_valid || i_m_axis_tready)
        else $error("result overwrote a pending result");

    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> o_s_axis_tready && !cmd.start && !cmd.insert)
        else $error("capture outside idle");

endmodule

// ----- rtl/hspf_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hspf_datapath
// Item register, header checks, method match and session key memory scan.
// ----------------------------------------------------------------------------
module hspf_datapath import hspf_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [IN_W-1:0] i_item,
    input  t_cmd            i_cmd,
    output t_status         o_status
);
    logic [15:0]  r_eth;
    logic [7:0]   r_proto;
    logic [3:0]   r_ihl;
    logic [15:0]  r_tlen;
    logic [3:0]   r_toff;
    logic [KEY_W-1:0] r_key;
    logic [55:0]  r_head;

    logic [KEY_W-1:0] r_mem [SESSION_ENTRIES];
    logic [KEY_W-1:0] r_rd_data;
    logic [COUNT_W-1:0] r_count, r_idx;
    logic r_scan, r_pend;

    logic [7:0] b [7];
    logic [16:0] need;
    logic short_pl, match, stop, more, issue, done, early;
    t_verdict early_v;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_eth   <= i_item[15:0];
            r_proto <= i_item[23:16];
            r_ihl   <= i_item[27:24];
            r_tlen  <= i_item[43:28];
            r_toff  <= i_item[47:44];
            r_key   <= {i_item[79:48], i_item[111:80], i_item[127:112], i_item[143:128]};
            r_head  <= i_item[199:144];
        end
    end

    always_comb begin
        for (int k = 0; k < 7; k++) begin
            b[k] = r_head[8*(6-k) +: 8];
        end
    end

    assign need = 17'({r_ihl, 2'b00}) + 17'({r_toff, 2'b00}) + MIN_PAYLOAD;
    assign short_pl = {1'b0, r_tlen} < need;

    always_comb begin
        early   = 1'b1;
        early_v = V_NOT_IPV4;
        if (r_eth != ETH_IPV4) begin
            early_v = V_NOT_IPV4;
        end else if (r_proto != IP_TCP) begin
            early_v = V_NOT_TCP;
        end else if (short_pl) begin
            early_v = V_SHORT;
        end else begin
            early = 1'b0;
        end
    end

    assign o_status.early         = early;
    assign o_status.early_verdict = early_v;

    assign o_status.method =
        (b[0] == "H" && b[1] == "T" && b[2] == "T" && b[3] == "P") ||
        (b[0] == "G" && b[1] == "E" && b[2] == "T") ||
        (b[0] == "P" && b[1] == "O" && b[2] == "S" && b[3] == "T") ||
        (b[0] == "P" && b[1] == "U" && b[2] == "T") ||
        (b[0] == "D" && b[1] == "E" && b[2] == "L" && b[3] == "E" &&
         b[4] == "T" && b[5] == "E") ||
        (b[0] == "H" && b[1] == "E" && b[2] == "A" && b[3] == "D");

    // entries 0..count-1 are valid: slots fill in order and are never freed
    assign match = (r_rd_data == r_key);
    assign stop  = r_pend && match;
    assign more  = (r_idx != r_count);
    assign issue = r_scan && more && !stop;
    assign done  = r_scan && (stop || (!more && !r_pend));

    assign o_status.done = done;
    assign o_status.hit  = stop;
    assign o_status.full = (r_count == COUNT_W'(SESSION_ENTRIES));

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
        end
        if (i_cmd.insert && !o_status.full) begin
            r_mem[r_count[IDX_W-1:0]] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
            r_scan  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            if (i_cmd.insert && !o_status.full) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.start) begin
                r_scan <= 1'b1;
                r_idx  <= '0;
                r_pend <= 1'b0;
            end else begin
                if (done) begin
                    r_scan <= 1'b0;
                end
                r_pend <= issue;
                if (issue) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/hspf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hspf_ctrl
// Sequencer: capture, classify, scan, insert and hand over the result.
// ----------------------------------------------------------------------------
module hspf_ctrl import hspf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_free,
    input  t_status  i_status,
    output logic     o_in_ready,
    output t_cmd     o_cmd,
    output logic     o_res_load,
    output t_verdict o_verdict,
    output logic     o_fail
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_SCAN = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state   r_state, n_state;
    t_verdict r_verdict, n_verdict;
    logic     r_fail, n_fail;

    always_comb begin
        n_state     = r_state;
        n_verdict   = r_verdict;
        n_fail      = r_fail;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_res_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_fail = 1'b0;
                if (i_status.early) begin
                    n_verdict = i_status.early_verdict;
                    n_state   = S_OUT;
                end else begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.done) begin
                    n_state = S_OUT;
                    if (i_status.method) begin
                        n_verdict    = V_METHOD;
                        o_cmd.insert = !i_status.hit;
                        n_fail       = !i_status.hit && i_status.full;
                    end else if (i_status.hit) begin
                        n_verdict = V_HIT;
                    end else begin
                        n_verdict = V_NO_MATCH;
                    end
                end
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_verdict = r_verdict;
    assign o_fail    = r_fail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_verdict <= V_NOT_IPV4;
            r_fail    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_verdict <= n_verdict;
            r_fail    <= n_fail;
        end
    end

endmodule

// ----- dv/tb_http_session_packet_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_session_packet_filter
// Self-checking bench: a queue-fed driver sends packet header summaries, a
// monitor compares every keep/verdict/insert_failed item with a behavioral
// session-set model kept in the bench. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_http_session_packet_filter;
    import hspf_pkg::*;

    typedef struct packed {
        logic [55:0] payload_head;
        logic [15:0] dest_port;
        logic [15:0] source_port;
        logic [31:0] dest_ip;
        logic [31:0] source_ip;
        logic [3:0]  tcp_offset_words;
        logic [15:0] ip_total_length;
        logic [3:0]  ip_header_words;
        logic [7:0]  ip_protocol;
        logic [15:0] ether_type;
    } t_hdr;

    typedef struct packed {
        logic     insert_failed;
        t_verdict verdict;
        logic     keep;
    } t_decision;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_axis_tvalid;
    logic             o_s_axis_tready;
    logic [IN_W-1:0]  i_s_axis_tdata;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready;
    logic [OUT_W-1:0] o_m_axis_tdata;

    http_session_packet_filter dut (.*);

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    t_hdr        pending_hdrs[$];
    t_decision   expected_decisions[$];
    logic [95:0] flow_keys[$];       // bench copy of the session set, slot order
    int          mismatch_count = 0;

    function automatic bit is_method(logic [55:0] h);
        logic [7:0] b[7];
        for (int k = 0; k < 7; k++) b[k] = h[55 - 8*k -: 8];
        return (b[0] == "H" && b[1] == "T" && b[2] == "T" && b[3] == "P") ||
               (b[0] == "G" && b[1] == "E" && b[2] == "T") ||
               (b[0] == "P" && b[1] == "O" && b[2] == "S" && b[3] == "T") ||
               (b[0] == "P" && b[1] == "U" && b[2] == "T") ||
               (b[0] == "D" && b[1] == "E" && b[2] == "L" && b[3] == "E" &&
                b[4] == "T" && b[5] == "E") ||
               (b[0] == "H" && b[1] == "E" && b[2] == "A" && b[3] == "D");
    endfunction

    function automatic bit flow_known(logic [95:0] k);
        foreach (flow_keys[i]) if (flow_keys[i] == k) return 1;
        return 0;
    endfunction

    // Decision for one header; updates the session set on a method match.
    function automatic t_decision filter_decision(t_hdr h);
        t_decision   d;
        logic [95:0] k;
        int          hdrs;
        int          plen;
        d = '0;
        k = {h.source_ip, h.dest_ip, h.source_port, h.dest_port};
        hdrs = 4 * h.ip_header_words + 4 * h.tcp_offset_words;
        plen = int'(h.ip_total_length) - hdrs;
        if (h.ether_type != ETH_IPV4) d.verdict = V_NOT_IPV4;
        else if (h.ip_protocol != IP_TCP) d.verdict = V_NOT_TCP;
        else if (plen < 7) d.verdict = V_SHORT;
        else if (is_method(h.payload_head)) begin
            d.verdict = V_METHOD;
            d.keep = 1'b1;
            if (!flow_known(k)) begin
                if (flow_keys.size() < SESSION_ENTRIES) flow_keys.push_back(k);
                else d.insert_failed = 1'b1;
            end
        end else if (flow_known(k)) begin
            d.verdict = V_HIT;
            d.keep = 1'b1;
        end else d.verdict = V_NO_MATCH;
        return d;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        mismatch_count++;
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Handshake seen at the last rising edge.
    logic o_s_axis_tready_q = 1'b0;
    always @(posedge i_clk) o_s_axis_tready_q <= o_s_axis_tready & i_s_axis_tvalid;

    // Driver: changes inputs at the falling edge.
    int  send_gap = 0;
    int  recv_gap = 0;
    bit  calm_send = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready_q) begin
                expected_decisions.push_back(filter_decision(t_hdr'(i_s_axis_tdata)));
                send_gap = calm_send ? 0 : gap_len();
            end
            if (!(i_s_axis_tvalid && !o_s_axis_tready_q)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pending_hdrs.size() > 0) begin
                    i_s_axis_tdata  <= pending_hdrs.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
            if ($urandom_range(0, 299) == 0) calm_send = !calm_send;
            if (recv_gap > 0) begin
                recv_gap--;
                i_m_axis_tready <= 1'b0;
            end else if (calm_send) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                recv_gap = gap_len();
                i_m_axis_tready <= (recv_gap == 0);
            end
        end
    end

    // Monitor: samples outputs at the rising edge.
    always @(posedge i_clk) begin
        t_decision got;
        t_decision want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_decision'(o_m_axis_tdata[4:0]);
            if (expected_decisions.size() == 0) begin
                report_mismatch("unexpected item", int'(o_m_axis_tdata), -1);
            end else begin
                want = expected_decisions.pop_front();
                if (got.keep != want.keep)
                    report_mismatch("keep", int'(got.keep), int'(want.keep));
                if (got.verdict != want.verdict)
                    report_mismatch("verdict", int'(got.verdict), int'(want.verdict));
                if (got.insert_failed != want.insert_failed)
                    report_mismatch("insert_failed", int'(got.insert_failed),
                                    int'(want.insert_failed));
                if (o_m_axis_tdata[7:5] != 3'b000)
                    report_mismatch("pad bits", int'(o_m_axis_tdata[7:5]), 0);
            end
        end
    end

    function automatic t_hdr rand_hdr();
        t_hdr         h;
        logic [223:0] w;
        w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        h = w[199:0];
        return h;
    endfunction

    // Well-formed IPv4/TCP header with a payload of at least 7 bytes.
    function automatic t_hdr tcp_hdr(logic [95:0] k, logic [55:0] head);
        t_hdr h;
        h = rand_hdr();
        h.ether_type = ETH_IPV4;
        h.ip_protocol = IP_TCP;
        h.ip_total_length = 16'(4 * h.ip_header_words + 4 * h.tcp_offset_words
                                + $urandom_range(7, 1400));
        {h.source_ip, h.dest_ip, h.source_port, h.dest_port} = k;
        h.payload_head = head;
        return h;
    endfunction

    function automatic logic [55:0] method_head(int m);
        logic [55:0] r;
        logic [63:0] w;
        w = {$urandom, $urandom};
        r = w[55:0];
        case (m)
            0: r[55:24] = "HTTP";
            1: r[55:32] = "GET";
            2: r[55:24] = "POST";
            3: r[55:32] = "PUT";
            4: r[55:8]  = "DELETE";
            default: r[55:24] = "HEAD";
        endcase
        return r;
    endfunction

    // Near-miss payloads: one bit flipped in one of the first six bytes of a method head.
    function automatic logic [55:0] spoiled_head();
        logic [55:0] r;
        int          p;
        r = method_head($urandom_range(0, 5));
        p = $urandom_range(0, 5);
        r[55 - 8*p -: 8] = r[55 - 8*p -: 8] ^ 8'(1 << $urandom_range(0, 7));
        return r;
    endfunction

    logic [95:0] key_pool[64];

    initial begin
        t_hdr        h;
        logic [95:0] k;
        logic [63:0] w;
        int          r;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom, $urandom};
        // directed: extremes, each verdict, underflow, near misses
        h = '0; pending_hdrs.push_back(h);
        h = '1; pending_hdrs.push_back(h);
        h = tcp_hdr('1, method_head(0)); h.ether_type = 16'h0801;
        pending_hdrs.push_back(h);
        h = tcp_hdr('1, method_head(0)); h.ip_protocol = 8'd17;
        pending_hdrs.push_back(h);
        h = tcp_hdr('0, method_head(1)); h.ip_header_words = 4'hf;
        h.tcp_offset_words = 4'hf; h.ip_total_length = 16'd119;   // underflow
        pending_hdrs.push_back(h);
        h.ip_total_length = 16'd126; pending_hdrs.push_back(h);  // 6 bytes
        h.ip_total_length = 16'd127; pending_hdrs.push_back(h);  // 7 bytes
        h = tcp_hdr('0, method_head(1)); h.ip_header_words = 4'd0;
        h.tcp_offset_words = 4'd0;
        h.ip_total_length = 16'hffff; pending_hdrs.push_back(h);
        for (int m = 0; m < 6; m++) pending_hdrs.push_back(tcp_hdr(key_pool[m], method_head(m)));
        pending_hdrs.push_back(tcp_hdr(key_pool[0], method_head(2)));  // already present
        pending_hdrs.push_back(tcp_hdr(key_pool[3], 56'h0));           // session hit
        pending_hdrs.push_back(tcp_hdr(key_pool[40], 56'hff_ffff_ffff_ffff));
        pending_hdrs.push_back(tcp_hdr(key_pool[41], spoiled_head()));
        pending_hdrs.push_back(tcp_hdr(key_pool[42], spoiled_head()));
        // fill the set to capacity, then probe full and hit behavior
        for (int i = 0; i < SESSION_ENTRIES; i++) begin
            k = {32'hc0a8_0000 + i, $urandom, 16'(i), 16'd80};
            pending_hdrs.push_back(tcp_hdr(k, method_head(i % 6)));
        end
        for (int i = 0; i < 800; i++) begin
            r = $urandom_range(0, 99);
            k = (r < 70) ? key_pool[$urandom_range(0, 63)] : {$urandom, $urandom, $urandom};
            w = {$urandom, $urandom};
            if (r < 35) h = tcp_hdr(k, method_head($urandom_range(0, 5)));
            else if (r < 75) h = tcp_hdr(k, w[55:0]);
            else if (r < 85) h = tcp_hdr(k, spoiled_head());
            else if (r < 92) begin
                h = tcp_hdr(k, method_head($urandom_range(0, 5)));
                h.ip_total_length = 16'($urandom_range(0, 130));
            end else h = rand_hdr();
            if ($urandom_range(0, 19) == 0) h.ether_type = ETH_IPV4;
            pending_hdrs.push_back(h);
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (pending_hdrs.size() == 0 && !i_s_axis_tvalid);
        wait (expected_decisions.size() == 0);
        repeat (1200) @(posedge i_clk);
        if (mismatch_count == 0 && expected_decisions.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // 1843 items, each with a scan over up to 1024 stored keys plus stalls
    initial begin
        #60ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/hspf_pkg.sv
rtl/hspf_datapath.sv
rtl/hspf_ctrl.sv
rtl/http_session_packet_filter.sv
dv/tb_http_session_packet_filter.sv
